FILE: hdl/arpc_pkg.sv
// Shared types and constants for the ARP cache table.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned IP_W      = 32;
  localparam int unsigned MAC_W     = 48;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OUT_CNT_W = 11;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(300);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_AGE    = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_e;

  typedef struct packed {
    logic [IP_W-1:0]   key;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] stamp;
    logic              stat;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

FILE: hdl/arpc_req_if.sv
// Request channel of the ARP cache table: valid/ready plus one table operation.
// Depends on arpc_pkg.
`timescale 1ns / 1ps

interface arpc_req_if;
  import arpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IP_W-1:0]   ip_addr;
  logic [MAC_W-1:0]  hw_addr;
  logic              pinned;
  logic [TIME_W-1:0] now;

  modport source (output valid, mode, ip_addr, hw_addr, pinned, now, input ready);
  modport sink   (input valid, mode, ip_addr, hw_addr, pinned, now, output ready);
endinterface

FILE: hdl/arpc_rsp_if.sv
// Response channel of the ARP cache table: valid/ready plus one result.
// Depends on arpc_pkg.
`timescale 1ns / 1ps

interface arpc_rsp_if;
  import arpc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [MAC_W-1:0]     found_mac;
  logic [OUT_CNT_W-1:0] entries_used;
  logic [OUT_CNT_W-1:0] aged_out;

  modport source (output valid, status, found_mac, entries_used, aged_out, input ready);
  modport sink   (input valid, status, found_mac, entries_used, aged_out, output ready);
endinterface

FILE: hdl/arpc_cfg_if.sv
// Configuration write channel: valid/ready plus the aging timeout value.
// Depends on arpc_pkg.
`timescale 1ns / 1ps

interface arpc_cfg_if;
  import arpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/arp_cache_table_unit.sv
// ARP cache table: IPv4-to-MAC entries kept packed in slots 0 .. entries_used-1 of a
// single entry memory (key, MAC, stamp, static flag) read at most one slot per cycle.
// Add and lookup scan the slots linearly (a hit stops the scan early); an add to a
// full table is answered without a scan. An aging pass checks each entry in turn; a
// removal reads the last slot and writes it into the freed one, unless the removed
// entry is itself the last. The one read port of the entry memory paces the scans.
// One operation is in work at a time; a new request is taken as soon as the previous
// result sits in the output register, even if that result is not yet taken.
// The timeout register may be written whenever the table is idle. No clearing pass
// follows reset: slots at or beyond the count are never read.
// Depends on arpc_pkg, the channel interfaces and arpc_ram.
`timescale 1ns / 1ps

module arp_cache_table_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  arpc_req_if.sink   req_i,
  arpc_rsp_if.source rsp_o,
  arpc_cfg_if.sink   cfg_i
);
  import arpc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SRCH  = 3'd1;
  localparam logic [2:0] ST_AGRD  = 3'd2;
  localparam logic [2:0] ST_AGCHK = 3'd3;
  localparam logic [2:0] ST_AGMV  = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [TIME_W-1:0]    timeout_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     iss_q, iss_d;
  logic                 pend_q, pend_d;
  logic [IDX_W-1:0]     pend_idx_q, pend_idx_d;
  logic [CNT_W-1:0]     k_q, k_d;
  logic [CNT_W-1:0]     removed_q, removed_d;
  status_e              res_status_q, res_status_d;
  logic [MAC_W-1:0]     res_mac_q, res_mac_d;

  logic [MODE_W-1:0]    mode_q;
  logic [IP_W-1:0]      ip_q;
  logic [MAC_W-1:0]     mac_q;
  logic                 stat_q;
  logic [TIME_W-1:0]    now_q;

  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  logic [STATUS_W-1:0]  out_status_q;
  logic [MAC_W-1:0]     out_mac_q;
  logic [OUT_CNT_W-1:0] out_used_q;
  logic [OUT_CNT_W-1:0] out_aged_q;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]   rd_raw;
  entry_t               rd_entry;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;

  logic                 accept;
  logic                 out_free;
  logic                 hit;
  logic                 expired;
  logic                 full;
  logic [CNT_W-1:0]     last_idx;
  logic [TIME_W-1:0]    age;

  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign cfg_i.ready = 1'b1;

  assign full     = (count_q >= CNT_W'(TABLE_DEPTH));
  assign last_idx = count_q - CNT_W'(1);
  assign hit      = pend_q && (rd_entry.key == ip_q);
  assign age      = now_q - rd_entry.stamp;
  assign expired  = !rd_entry.stat && (age > timeout_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    iss_d        = iss_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    k_d          = k_q;
    removed_d    = removed_q;
    res_status_d = res_status_q;
    res_mac_d    = res_mac_q;
    out_load     = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = iss_q[IDX_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = count_q[IDX_W-1:0];
    wr_data      = '{key: ip_q, mac: mac_q, stamp: now_q, stat: stat_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          iss_d        = '0;
          pend_d       = 1'b0;
          k_d          = '0;
          removed_d    = '0;
          res_status_d = STATUS_OK;
          res_mac_d    = '0;
          unique case (mode_e'(req_i.mode))
            MODE_ADD: begin
              if (full) begin
                res_status_d = STATUS_FULL;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_SRCH;
              end
            end
            MODE_LOOKUP: state_d = ST_SRCH;
            MODE_AGE:    state_d = ST_AGRD;
            default:     state_d = ST_RESP;
          endcase
        end
      end

      ST_SRCH: begin
        if (hit) begin
          // overwrite in place on add, return the MAC on lookup
          pend_d = 1'b0;
          if (mode_q == MODE_ADD) begin
            wr_en   = 1'b1;
            wr_addr = pend_idx_q;
          end else begin
            res_mac_d = rd_entry.mac;
          end
          state_d = ST_RESP;
        end else if (iss_q < count_q) begin
          rd_en      = 1'b1;
          rd_addr    = iss_q[IDX_W-1:0];
          iss_d      = iss_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = iss_q[IDX_W-1:0];
        end else begin
          // miss: append on add
          pend_d = 1'b0;
          if (mode_q == MODE_ADD) begin
            wr_en   = 1'b1;
            wr_addr = count_q[IDX_W-1:0];
            count_d = count_q + CNT_W'(1);
          end else begin
            res_status_d = STATUS_MISS;
          end
          state_d = ST_RESP;
        end
      end

      ST_AGRD: begin
        if (k_q < count_q) begin
          rd_en   = 1'b1;
          rd_addr = k_q[IDX_W-1:0];
          state_d = ST_AGCHK;
        end else begin
          state_d = ST_RESP;
        end
      end

      ST_AGCHK: begin
        if (expired) begin
          count_d   = last_idx;
          removed_d = removed_q + CNT_W'(1);
          if (k_q < last_idx) begin
            // fetch the last entry to fill the hole, then check this slot again
            rd_en   = 1'b1;
            rd_addr = last_idx[IDX_W-1:0];
            state_d = ST_AGMV;
          end else begin
            state_d = ST_AGRD;
          end
        end else begin
          k_d     = k_q + CNT_W'(1);
          state_d = ST_AGRD;
        end
      end

      ST_AGMV: begin
        wr_en   = 1'b1;
        wr_addr = k_q[IDX_W-1:0];
        wr_data = rd_entry;
        state_d = ST_AGRD;
      end

      ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timeout_q   <= TIMEOUT_RESET;
      count_q     <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      k_q         <= '0;
      removed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      k_q         <= k_d;
      removed_q   <= removed_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        timeout_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    res_status_q <= res_status_d;
    res_mac_q    <= res_mac_d;
    if (accept) begin
      mode_q <= req_i.mode;
      ip_q   <= req_i.ip_addr;
      mac_q  <= req_i.hw_addr;
      stat_q <= req_i.pinned;
      now_q  <= req_i.now;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_mac_q    <= res_mac_q;
      out_used_q   <= OUT_CNT_W'(count_q);
      out_aged_q   <= OUT_CNT_W'(removed_q);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.found_mac    = out_mac_q;
  assign rsp_o.entries_used = out_used_q;
  assign rsp_o.aged_out     = out_aged_q;

endmodule

FILE: hdl/arpc_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module arpc_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/arpc_checker.sv
// Port-level checks on the ARP cache table responses, bound to arp_cache_table_unit.
// Depends on arpc_pkg and arp_cache_table_unit.
`timescale 1ns / 1ps

module arpc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [arpc_pkg::STATUS_W-1:0]  status_i,
  input logic [arpc_pkg::MAC_W-1:0]     found_mac_i,
  input logic [arpc_pkg::OUT_CNT_W-1:0] entries_used_i,
  input logic [arpc_pkg::OUT_CNT_W-1:0] aged_out_i
);
  import arpc_pkg::*;

  // a stalled result holds until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i)
      && $stable(found_mac_i) && $stable(entries_used_i) && $stable(aged_out_i))
    else $error("response changed while stalled");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != STATUS_OK |-> found_mac_i == '0 && aged_out_i == '0)
    else $error("failed request carries MAC or aged count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == STATUS_FULL |-> entries_used_i == OUT_CNT_W'(TABLE_DEPTH))
    else $error("table full reported below capacity");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> entries_used_i <= OUT_CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

endmodule

bind arp_cache_table_unit arpc_checker u_arpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .found_mac_i    (rsp_o.found_mac),
  .entries_used_i (rsp_o.entries_used),
  .aged_out_i     (rsp_o.aged_out)
);
